### hdl/gfau_pkg.sv
package gfau_pkg;

  // Field polynomial x^8 + x^4 + x^3 + x + 1: the low byte folds back on a multiply by x,
  // the full nine bits reduce a squared element.
  localparam logic [7:0] POLY_LOW  = 8'h1B;
  localparam logic [8:0] POLY_FULL = 9'h11B;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_MUL = 2'd1,
    OP_QUO = 2'd2,
    OP_INV = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] a;
    logic [7:0] b;
  } in_t;

  // Stage payload. The x fields hold the add or multiply result in x0, or the
  // partial products of the inverse power chain.
  typedef struct packed {
    op_t        op;
    logic [7:0] divisor;
    logic [2:0] deg;
    logic [7:0] rem;
    logic [7:0] quo;
    logic [7:0] x0;
    logic [7:0] x1;
    logic [7:0] x2;
    logic [7:0] x3;
  } pipe_t;

  typedef struct packed {
    logic [7:0] result;
    logic       divide_by_zero;
  } out_t;

  function automatic logic [7:0] gf_mul_x(logic [7:0] v);
    logic [7:0] s;
    s = {v[6:0], 1'b0};
    return v[7] ? (s ^ POLY_LOW) : s;
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int i = 7; i >= 0; i--) begin
      acc = gf_mul_x(acc);
      if (a[i]) acc = acc ^ b;
    end
    return acc;
  endfunction

  // Squaring is linear over GF(2): spread the bits, then reduce.
  function automatic logic [7:0] gf_sqr(logic [7:0] v);
    logic [14:0] t;
    t = '0;
    for (int i = 0; i < 8; i++) t[2*i] = v[i];
    for (int k = 14; k >= 8; k--) begin
      if (t[k]) t = t ^ (15'(POLY_FULL) << (k - 8));
    end
    return t[7:0];
  endfunction

  function automatic logic [2:0] poly_deg(logic [7:0] v);
    logic [2:0] d;
    d = '0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) d = 3'(i);
    end
    return d;
  endfunction

  // One step of long division: tries quotient bit pos.
  function automatic pipe_t div_step(pipe_t p, logic [2:0] pos);
    logic [3:0] idx;
    pipe_t      r;
    r   = p;
    idx = {1'b0, pos} + {1'b0, p.deg};
    if (!idx[3] && p.rem[idx[2:0]]) begin
      r.quo[pos] = 1'b1;
      r.rem      = p.rem ^ (p.divisor << pos);
    end
    return r;
  endfunction

endpackage

### hdl/gfau_if.sv
interface gfau_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] operand_a;
  logic [7:0] operand_b;

  modport source (output valid, output operation, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input operation, input operand_a, input operand_b,
                  output ready);
endinterface

interface gfau_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] result;
  logic       divide_by_zero;

  modport source (output valid, output result, output divide_by_zero, input ready);
  modport sink   (input valid, input result, input divide_by_zero, output ready);
endinterface

### hdl/gfau_stage1.sv
module gfau_stage1 (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  gfau_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output gfau_pkg::pipe_t out_data
);

  gfau_pkg::pipe_t  stage_next;
  logic [7:1][7:0]  pw;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    // Powers a^(2^k) for the inverse chain.
    pw[1] = gfau_pkg::gf_sqr(in_data.a);
    pw[2] = gfau_pkg::gf_sqr(pw[1]);
    pw[3] = gfau_pkg::gf_sqr(pw[2]);
    pw[4] = gfau_pkg::gf_sqr(pw[3]);
    pw[5] = gfau_pkg::gf_sqr(pw[4]);
    pw[6] = gfau_pkg::gf_sqr(pw[5]);
    pw[7] = gfau_pkg::gf_sqr(pw[6]);

    stage_next         = '0;
    stage_next.op      = in_data.op;
    stage_next.divisor = in_data.b;
    stage_next.deg     = gfau_pkg::poly_deg(in_data.b);
    stage_next.rem     = in_data.a;
    stage_next         = gfau_pkg::div_step(stage_next, 3'd7);
    stage_next         = gfau_pkg::div_step(stage_next, 3'd6);
    stage_next         = gfau_pkg::div_step(stage_next, 3'd5);

    case (in_data.op)
      gfau_pkg::OP_ADD: stage_next.x0 = in_data.a ^ in_data.b;
      gfau_pkg::OP_MUL: stage_next.x0 = gfau_pkg::gf_mul(in_data.a, in_data.b);
      gfau_pkg::OP_INV: begin
        stage_next.x0 = gfau_pkg::gf_mul(pw[1], pw[2]);
        stage_next.x1 = gfau_pkg::gf_mul(pw[3], pw[4]);
        stage_next.x2 = gfau_pkg::gf_mul(pw[5], pw[6]);
        stage_next.x3 = pw[7];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= stage_next;
    end
  end

endmodule

### hdl/gfau_stage2.sv
module gfau_stage2 (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  gfau_pkg::pipe_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output gfau_pkg::pipe_t out_data
);

  gfau_pkg::pipe_t stage_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    stage_next = gfau_pkg::div_step(in_data, 3'd4);
    stage_next = gfau_pkg::div_step(stage_next, 3'd3);
    stage_next = gfau_pkg::div_step(stage_next, 3'd2);
    // Second level of the inverse product tree.
    if (in_data.op == gfau_pkg::OP_INV) begin
      stage_next.x0 = gfau_pkg::gf_mul(in_data.x0, in_data.x1);
      stage_next.x1 = gfau_pkg::gf_mul(in_data.x2, in_data.x3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= stage_next;
    end
  end

endmodule

### hdl/gfau_stage3.sv
module gfau_stage3 (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  gfau_pkg::pipe_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output gfau_pkg::out_t  out_data
);

  gfau_pkg::pipe_t div_last;
  gfau_pkg::out_t  stage_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    div_last = gfau_pkg::div_step(in_data, 3'd1);
    div_last = gfau_pkg::div_step(div_last, 3'd0);
    stage_next = '0;
    case (in_data.op)
      gfau_pkg::OP_ADD,
      gfau_pkg::OP_MUL: stage_next.result = in_data.x0;
      gfau_pkg::OP_QUO: begin
        if (in_data.divisor == 8'd0) begin
          stage_next.divide_by_zero = 1'b1;
        end else begin
          stage_next.result = div_last.quo;
        end
      end
      gfau_pkg::OP_INV: stage_next.result = gfau_pkg::gf_mul(in_data.x0, in_data.x1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= stage_next;
    end
  end

endmodule

### hdl/gf256_arithmetic_unit.sv
// GF(2^8) arithmetic unit over the AES field polynomial x^8 + x^4 + x^3 + x + 1.
// Each request transfer carries an operation and two bytes and yields exactly one
// response transfer: add (XOR), field multiply, plain polynomial long-division
// quotient with no reduction, or the inverse of operand_a computed as a^254 (so
// the inverse of zero is zero). A quotient with a zero divisor returns zero and
// sets divide_by_zero, which is low for every other operation. The block takes
// one request per clock while the response side does not stall, and each
// response leaves from the last of three pipeline stages. Each stage holds one
// level of the inverse product tree and three, three and two steps of the long
// division. Each stage stalls on its own, so bubbles are squeezed out and a
// waiting response never drops or repeats data.
module gf256_arithmetic_unit (
  input  logic       clk,
  input  logic       rst,
  gfau_req_if.sink   req,
  gfau_rsp_if.source rsp
);

  gfau_pkg::in_t   req_data;
  gfau_pkg::pipe_t s1_data;
  gfau_pkg::pipe_t s2_data;
  gfau_pkg::out_t  s3_data;
  logic            s1_valid;
  logic            s1_ready;
  logic            s2_valid;
  logic            s2_ready;

  // The two-bit operation field maps onto all four operation codes.
  assign req_data.op = gfau_pkg::op_t'(req.operation);
  assign req_data.a  = req.operand_a;
  assign req_data.b  = req.operand_b;

  // First stage: squaring chain, first product level, top quotient bits.
  gfau_stage1 u_stage1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_data   (req_data),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  // Second stage: middle quotient bits and the second product level.
  gfau_stage2 u_stage2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  // Third stage: last quotient bits, final product and result selection.
  // Its register is the output register of the block.
  gfau_stage3 u_stage3 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (s3_data)
  );

  assign rsp.result         = s3_data.result;
  assign rsp.divide_by_zero = s3_data.divide_by_zero;

endmodule

### hdl/gfau_check.sv
module gfau_check (
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_result,
  input logic       rsp_dz
);

  // A response held back by the sink stays offered.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response withdrawn while stalled");

  // A stalled response keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_result) && $stable(rsp_dz))
    else $error("response payload changed while stalled");

  // A divide-by-zero response always carries a zero result.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_dz |-> rsp_result == 8'd0)
    else $error("divide by zero with nonzero result");

  // Reset empties the pipeline.
  assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind gf256_arithmetic_unit gfau_check u_check (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_result (rsp.result),
  .rsp_dz     (rsp.divide_by_zero)
);

### dv/tb.sv
module tb;

  // Slowest correct run: roughly 1200 requests, each behind the longest sender gap
  // and the longest response stall plus the pipeline depth.
  // The watchdog allows several times that.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned CALM_ITEMS   = 150;
  localparam int unsigned DRAIN_CYCLES = 10;

  // One expected response, together with the request that produced it so that a
  // mismatch message can name the operation and operands.
  typedef struct {
    gfau_pkg::op_t op;
    logic [7:0]    a;
    logic [7:0]    b;
    logic [7:0]    result;
    logic          divide_by_zero;
  } gf_answer_t;

  logic clk = 1'b0;
  logic rst;

  gfau_req_if req_bus ();
  gfau_rsp_if rsp_bus ();

  gf256_arithmetic_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // Answers are queued in request order. The block never reorders, so each
  // response transfer is matched with the oldest entry.
  gf_answer_t  pending_answers[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // When this is low, neither side inserts gaps or stalls. The random test turns
  // it off in some stretches, and the final test keeps it off throughout.
  bit idle_on = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: GF(2^8) arithmetic over x^8 + x^4 + x^3 + x + 1.
  // ---------------------------------------------------------------------------

  // Multiplying by x shifts left. A carry out of bit 7 folds back as x^4+x^3+x+1.
  function automatic logic [7:0] times_x(logic [7:0] v);
    logic [7:0] shifted;
    shifted = {v[6:0], 1'b0};
    return v[7] ? (shifted ^ 8'h1b) : shifted;
  endfunction

  // Horner form: walk the bits of the first factor from the top down.
  function automatic logic [7:0] field_product(logic [7:0] x, logic [7:0] y);
    logic [7:0] acc;
    acc = 8'h00;
    for (int bit_idx = 7; bit_idx >= 0; bit_idx--) begin
      acc = times_x(acc);
      if (x[bit_idx]) acc = acc ^ y;
    end
    return acc;
  endfunction

  // The inverse is x^254 = x^2 * x^4 * ... * x^128. Zero maps to zero.
  function automatic logic [7:0] field_inverse(logic [7:0] x);
    logic [7:0] acc;
    logic [7:0] power;
    acc   = 8'h01;
    power = x;
    for (int k = 0; k < 7; k++) begin
      power = field_product(power, power);
      acc   = field_product(acc, power);
    end
    return acc;
  endfunction

  function automatic int degree_of(logic [7:0] v);
    for (int d = 7; d >= 0; d--) begin
      if (v[d]) return d;
    end
    return -1;
  endfunction

  // Plain polynomial long division over GF(2), with no field reduction. The
  // divisor must be nonzero. A divisor of higher degree than the dividend gives 0.
  function automatic logic [7:0] long_div_quotient(logic [7:0] dividend, logic [7:0] divisor);
    int         dg;
    logic [7:0] rem;
    logic [7:0] quo;
    dg  = degree_of(divisor);
    rem = dividend;
    quo = 8'h00;
    for (int pos = 7 - dg; pos >= 0; pos--) begin
      if (rem[pos + dg]) begin
        quo[pos] = 1'b1;
        rem      = rem ^ 8'(divisor << pos);
      end
    end
    return quo;
  endfunction

  function automatic gf_answer_t compute_gf_answer(gfau_pkg::op_t op, logic [7:0] a,
                                                   logic [7:0] b);
    gf_answer_t ans;
    ans.op             = op;
    ans.a              = a;
    ans.b              = b;
    ans.result         = 8'h00;
    ans.divide_by_zero = 1'b0;
    case (op)
      gfau_pkg::OP_ADD: ans.result = a ^ b;
      gfau_pkg::OP_MUL: ans.result = field_product(a, b);
      gfau_pkg::OP_QUO: begin
        // A zero divisor raises the flag and forces the result to zero.
        if (b == 8'h00) ans.divide_by_zero = 1'b1;
        else ans.result = long_div_quotient(a, b);
      end
      default: ans.result = field_inverse(a);
    endcase
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting and checking.
  // ---------------------------------------------------------------------------

  // Every mismatch is printed on one line and counted.
  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  // Every response transfer is compared, field by field, with the oldest answer.
  // The response side is sampled at the rising edge. ready and valid were set by
  // nonblocking updates, so the values read here are the ones at the edge.
  always @(posedge clk) begin
    gf_answer_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("response with nothing outstanding: result=%02h dz=%0b",
                                  rsp_bus.result, rsp_bus.divide_by_zero));
      end else begin
        want = pending_answers.pop_front();
        if (rsp_bus.result !== want.result)
          report_mismatch($sformatf("%s a=%02h b=%02h: result %02h, expected %02h",
                                    want.op.name(), want.a, want.b, rsp_bus.result,
                                    want.result));
        if (rsp_bus.divide_by_zero !== want.divide_by_zero)
          report_mismatch($sformatf("%s a=%02h b=%02h: divide_by_zero %0b, expected %0b",
                                    want.op.name(), want.a, want.b,
                                    rsp_bus.divide_by_zero, want.divide_by_zero));
      end
    end
  end

  // Watchdog. A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d responses outstanding",
               cycle_count, pending_answers.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Response side: ready drops in random bursts while idling is enabled, and
  // stays high otherwise.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side.
  // ---------------------------------------------------------------------------

  // Sends one request and returns at the edge where it was accepted. valid stays
  // high afterwards. Either the next call replaces the payload in the same time
  // step, or it lowers valid for a gap. The caller lowers valid after the last
  // request. This way valid gets at most one nonblocking update per time step.
  task automatic send_request(gfau_pkg::op_t op, logic [7:0] a, logic [7:0] b);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    req_bus.valid     <= 1'b1;
    req_bus.operation <= op;
    req_bus.operand_a <= a;
    req_bus.operand_b <= b;
    do @(posedge clk); while (!req_bus.ready);
    pending_answers.push_back(compute_gf_answer(op, a, b));
  endtask

  // Operand bytes favor zero, all ones and single-bit values. These are the
  // interesting divisor and dividend degrees, and the zero divisor of the quotient.
  function automatic logic [7:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'(1 << $urandom_range(0, 7));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed tests.
  // ---------------------------------------------------------------------------

  // XOR at the extremes and with alternating bits.
  task automatic test_add();
    send_request(gfau_pkg::OP_ADD, 8'h00, 8'h00);
    send_request(gfau_pkg::OP_ADD, 8'hff, 8'hff);
    send_request(gfau_pkg::OP_ADD, 8'hff, 8'h00);
    send_request(gfau_pkg::OP_ADD, 8'haa, 8'h55);
  endtask

  // Zero and one factors, the reduction carry at x^7 * x, a textbook product,
  // and the largest operands.
  task automatic test_multiply();
    send_request(gfau_pkg::OP_MUL, 8'h00, 8'hff);
    send_request(gfau_pkg::OP_MUL, 8'h01, 8'hc3);
    send_request(gfau_pkg::OP_MUL, 8'h80, 8'h02);
    send_request(gfau_pkg::OP_MUL, 8'h57, 8'h83);
    send_request(gfau_pkg::OP_MUL, 8'hff, 8'hff);
  endtask

  // Quotient special cases. A zero divisor gives 0 with the flag set, however
  // large the dividend. A zero dividend gives 0 with no flag. A divisor of higher
  // degree than the dividend gives 0. Then come a few ordinary divisions.
  task automatic test_quotient();
    send_request(gfau_pkg::OP_QUO, 8'hff, 8'h00);
    send_request(gfau_pkg::OP_QUO, 8'h00, 8'h00);
    send_request(gfau_pkg::OP_QUO, 8'h00, 8'h05);
    send_request(gfau_pkg::OP_QUO, 8'h03, 8'h80);
    send_request(gfau_pkg::OP_QUO, 8'hff, 8'h01);
    send_request(gfau_pkg::OP_QUO, 8'hff, 8'hff);
    send_request(gfau_pkg::OP_QUO, 8'h80, 8'h03);
    send_request(gfau_pkg::OP_QUO, 8'hb7, 8'h0d);
  endtask

  // Inverse of zero is zero and of one is one. operand_b is ignored, so it is
  // driven with junk.
  task automatic test_inverse();
    send_request(gfau_pkg::OP_INV, 8'h00, 8'hff);
    send_request(gfau_pkg::OP_INV, 8'h01, 8'h00);
    send_request(gfau_pkg::OP_INV, 8'hff, 8'h5a);
    send_request(gfau_pkg::OP_INV, 8'h53, 8'($urandom_range(0, 255)));
  endtask

  // Random operations and operands in blocks. Each block either idles at random
  // on both sides or runs with no idling at all.
  task automatic test_random_mix();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
      send_request(gfau_pkg::op_t'($urandom_range(0, 3)), pick_operand(), pick_operand());
    end
  endtask

  // The last stretch runs at full rate: one request and one response per clock.
  task automatic test_full_rate();
    idle_on = 1'b0;
    for (int n = 0; n < CALM_ITEMS; n++)
      send_request(gfau_pkg::op_t'($urandom_range(0, 3)), pick_operand(), pick_operand());
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst               <= 1'b1;
    req_bus.valid     <= 1'b0;
    req_bus.operation <= gfau_pkg::OP_ADD;
    req_bus.operand_a <= 8'h00;
    req_bus.operand_b <= 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The directed part runs with idling so that gaps hit the pipeline early.
    idle_on = 1'b1;
    test_add();
    test_multiply();
    test_quotient();
    test_inverse();
    test_random_mix();
    test_full_rate();
    req_bus.valid <= 1'b0;

    // Wait for the outstanding responses, then run on for DRAIN_CYCLES so that a
    // spurious extra transfer would still be caught.
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hdl/gfau_pkg.sv
hdl/gfau_if.sv
hdl/gfau_stage1.sv
hdl/gfau_stage2.sv
hdl/gfau_stage3.sv
hdl/gf256_arithmetic_unit.sv
hdl/gfau_check.sv
dv/tb.sv
